// ===== hw/rtl/usm_pkg.sv =====
`timescale 1ns / 1ps

package usm_pkg;

  // Pixel layout: element 0 is red, 1 green, 2 blue
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 3;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] rgb_t;

  // Fixed-point arithmetic
  localparam int FRAC_BITS  = 10;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
  localparam int PIX_MAX    = 255;

  // Register field widths
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_W     = 16;
  localparam int WEIGHT_W     = 16;
  localparam int ROW_W        = HEIGHT_W + 1;  // rows run past the frame while flushing
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_CENTER_WEIGHT  = 3'd2,
    CFG_EDGE_WEIGHT    = 3'd3,
    CFG_SHARPEN_ENABLE = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]     FRAME_WIDTH_RST    = 13'd1920;
  localparam logic [HEIGHT_W-1:0]        FRAME_HEIGHT_RST   = 16'd1080;
  localparam logic signed [WEIGHT_W-1:0] CENTER_WEIGHT_RST  = 16'sd1934;
  localparam logic signed [WEIGHT_W-1:0] EDGE_WEIGHT_RST    = -16'sd113;
  localparam logic                       SHARPEN_ENABLE_RST = 1'b1;

  // Channel payloads
  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    logic  pad;
  } pix_in_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  frame_last;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/usm_chan_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload beat
interface usm_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/unsharp_mask_sharpen_core.sv =====
`timescale 1ns / 1ps

// Unsharp-mask sharpening core for an RGB raster stream.
// Channels: in_pix (usm_pkg::pix_in_t beats), out_pix (usm_pkg::pix_out_t beats) and
// cfg_wr (usm_pkg::cfg_wr_t, register index plus data; always ready).
// One pixel beat is taken per clock while out_pix is not stalled and no register write
// is settling. The stream position of each output lags the input by KERNEL_SIZE/2 rows
// plus KERNEL_SIZE/2 pixels; after the frame the host sends that many pad beats so that
// the last outputs leave, the final one flagged frame_last.
// Column history lives in one line memory of MAX_WIDTH words, each holding the
// KERNEL_SIZE-1 previous rows of one column; every beat does a read at the accept edge
// and writes the updated word back from stage 1, held while out_pix is stalled, with a
// bypass when consecutive beats hit the same column (frame width of one).
// Reset clears positions and loads the default registers; the cycle after reset and the
// cycle after each register write recompute the frame totals, and in_pix.ready is low
// then. When out_pix is stalled the whole pipeline holds and in_pix.ready drops in the
// same cycle; the output register frees as soon as its beat is taken.
module unsharp_mask_sharpen_core #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  usm_chan_if.sink   cfg_wr,
  usm_chan_if.sink   in_pix,
  usm_chan_if.source out_pix
);

  localparam int HALF = KERNEL_SIZE / 2;
  localparam int NCH  = usm_pkg::NUM_CHAN;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = usm_pkg::ROW_W;
  localparam int NW   = WW + RW;
  localparam int FWX  = usm_pkg::WIDTH_REG_W + 1;
  localparam int HW   = usm_pkg::HEIGHT_W;
  localparam int CSW  = $clog2(KERNEL_SIZE * usm_pkg::PIX_MAX + 1);
  localparam int SW   = $clog2(KERNEL_SIZE * KERNEL_SIZE * usm_pkg::PIX_MAX + 1);
  localparam int PW   = usm_pkg::WEIGHT_W + SW + 2;

  typedef usm_pkg::rgb_t [KERNEL_SIZE-1:0] col_t;    // element 0 is the newest row
  typedef usm_pkg::rgb_t [KERNEL_SIZE-2:0] mword_t;  // element 0 is one row back
  typedef logic [KERNEL_SIZE-1:0][NCH-1:0][CSW-1:0] csum_t;

  typedef struct packed {
    logic emit;
    logic sharpen;
    logic last;
  } ictl_t;

  // Configuration registers
  logic [usm_pkg::WIDTH_REG_W-1:0]     frame_width_r;
  logic [HW-1:0]                       frame_height_r;
  logic signed [usm_pkg::WEIGHT_W-1:0] center_weight_r;
  logic signed [usm_pkg::WEIGHT_W-1:0] edge_weight_r;
  logic                                sharpen_enable_r;
  logic                                settle_r;

  // Position state
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic [NW-1:0] n_r, m_r, total_r, lag_r;

  // Pipeline
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_valid_r;
  ictl_t                s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r, s5_ctl_r;
  usm_pkg::rgb_t        s1_px_r, s3_ctr_r, s4_ctr_r, s5_ctr_r, out_rgb_r;
  logic [CW-1:0]        s1_col_r;
  col_t                 win_r [KERNEL_SIZE];
  csum_t                s3_cs_r;
  logic [NCH-1:0][SW-1:0] s4_nb_r;
  logic signed [PW-1:0] s5_pc_r [NCH];
  logic signed [PW-1:0] s5_pe_r [NCH];
  logic                 out_last_r;

  // Line memory and bypass
  mword_t line_mem [MAX_WIDTH];
  mword_t mem_q_r, byp_data_r, rd_word, wr_word;
  logic   byp_r;
  col_t   colv;

  logic en, in_rdy, in_acc, wr_en, rd_en;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= usm_pkg::FRAME_WIDTH_RST;
      frame_height_r   <= usm_pkg::FRAME_HEIGHT_RST;
      center_weight_r  <= usm_pkg::CENTER_WEIGHT_RST;
      edge_weight_r    <= usm_pkg::EDGE_WEIGHT_RST;
      sharpen_enable_r <= usm_pkg::SHARPEN_ENABLE_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.payload.reg_index)
        usm_pkg::CFG_FRAME_WIDTH: begin
          frame_width_r <= cfg_wr.payload.wr_data[usm_pkg::WIDTH_REG_W-1:0];
        end
        usm_pkg::CFG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wr.payload.wr_data[HW-1:0];
        end
        usm_pkg::CFG_CENTER_WEIGHT: begin
          center_weight_r <= $signed(cfg_wr.payload.wr_data[usm_pkg::WEIGHT_W-1:0]);
        end
        usm_pkg::CFG_EDGE_WEIGHT: begin
          edge_weight_r <= $signed(cfg_wr.payload.wr_data[usm_pkg::WEIGHT_W-1:0]);
        end
        usm_pkg::CFG_SHARPEN_ENABLE: begin
          sharpen_enable_r <= cfg_wr.payload.wr_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Effective frame size: width saturated to 1..MAX_WIDTH, zero height read as one
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if ({1'b0, frame_width_r} > FWX'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    h_eff = (frame_height_r == '0) ? HW'(1) : frame_height_r;
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign en           = !out_valid_r || out_pix.ready;
  assign in_rdy       = en && !settle_r && !cfg_wr.valid;
  assign in_pix.ready = in_rdy;
  assign in_acc       = in_pix.valid && in_rdy;
  assign rd_en        = in_acc;
  assign wr_en        = en && s1_v_r;

  // ---------------------------------------------------------------------------
  // Per-beat position bookkeeping
  logic [WW-1:0]  col_inc, ocol_inc;
  logic           in_wrap, out_wrap, in_frame, emit, interior, last;
  logic [CW-1:0]  in_col_nxt, out_col_nxt;
  logic [RW-1:0]  in_row_nxt, out_row_nxt;
  logic [NW-1:0]  n_nxt, m_nxt;
  usm_pkg::rgb_t  px_in, px_wr;

  always_comb begin
    col_inc    = WW'(in_col_r) + WW'(1);
    in_wrap    = col_inc >= w_eff;
    in_col_nxt = in_wrap ? '0 : CW'(col_inc);
    in_row_nxt = in_wrap ? in_row_r + RW'(1) : in_row_r;
    n_nxt      = in_wrap ? n_r + NW'(w_eff) - NW'(in_col_r) : n_r + NW'(1);

    ocol_inc    = WW'(out_col_r) + WW'(1);
    out_wrap    = ocol_inc >= w_eff;
    out_col_nxt = out_wrap ? '0 : CW'(ocol_inc);
    out_row_nxt = out_wrap ? out_row_r + RW'(1) : out_row_r;
    m_nxt       = out_wrap ? m_r + NW'(w_eff) - NW'(out_col_r) : m_r + NW'(1);

    in_frame = (n_r < total_r) && (WW'(in_col_r) < w_eff);
    emit     = n_r >= lag_r;
    last     = (m_r + NW'(1)) >= total_r;
    interior = (out_row_r >= RW'(HALF)) && ((out_row_r + RW'(HALF)) < RW'(h_eff))
               && (out_col_r >= CW'(HALF)) && ((WW'(out_col_r) + WW'(HALF)) < w_eff);

    px_in[0] = in_pix.payload.red_in;
    px_in[1] = in_pix.payload.green_in;
    px_in[2] = in_pix.payload.blue_in;
    px_wr    = (in_frame && !in_pix.payload.pad) ? px_in : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r  <= 1'b1;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      n_r       <= '0;
      m_r       <= '0;
    end else begin
      settle_r <= cfg_wr.valid;
      if (settle_r) begin
        // recompute derived sizes and linear positions under the current registers
        total_r <= NW'(w_eff) * NW'(h_eff);
        lag_r   <= NW'(w_eff) * NW'(HALF) + NW'(HALF);
        n_r     <= NW'(in_row_r) * NW'(w_eff) + NW'(in_col_r);
        m_r     <= NW'(out_row_r) * NW'(w_eff) + NW'(out_col_r);
      end else if (in_acc) begin
        if (emit && last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          n_r       <= '0;
          m_r       <= '0;
        end else begin
          in_col_r <= in_col_nxt;
          in_row_r <= in_row_nxt;
          n_r      <= n_nxt;
          if (emit) begin
            out_col_r <= out_col_nxt;
            out_row_r <= out_row_nxt;
            m_r       <= m_nxt;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: read at accept, write back the shifted column from stage 1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_col_r] <= wr_word;
    end
    if (rd_en) begin
      mem_q_r    <= line_mem[in_col_r];
      byp_r      <= wr_en && (s1_col_r == in_col_r);
      byp_data_r <= wr_word;
    end
  end

  // Stage 1: assemble the full column and the word to store
  always_comb begin
    rd_word = byp_r ? byp_data_r : mem_q_r;
    colv[0] = s1_px_r;
    for (int i = 1; i < KERNEL_SIZE; i++) begin
      colv[i] = rd_word[i-1];
    end
    for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
      wr_word[i] = colv[i];
    end
  end

  // Stage 2: column sums of the window
  csum_t cs;

  always_comb begin
    for (int j = 0; j < KERNEL_SIZE; j++) begin
      for (int c = 0; c < NCH; c++) begin
        cs[j][c] = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
          cs[j][c] = cs[j][c] + CSW'(win_r[j][i][c]);
        end
      end
    end
  end

  // Stage 3: neighbour sum (all taps less the centre)
  logic [NCH-1:0][SW-1:0] nb;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      nb[c] = '0;
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        nb[c] = nb[c] + SW'(s3_cs_r[j][c]);
      end
      nb[c] = nb[c] - SW'(s3_ctr_r[c]);
    end
  end

  // Stage 4: weight products
  logic signed [PW-1:0] pc [NCH];
  logic signed [PW-1:0] pe [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      pc[c] = PW'(center_weight_r) * $signed(PW'(s4_ctr_r[c]));
      pe[c] = PW'(edge_weight_r) * $signed(PW'(s4_nb_r[c]));
    end
  end

  // Stage 5: round, shift, clamp, select pass-through
  logic signed [PW-1:0] acc [NCH];
  logic signed [PW-1:0] shv [NCH];
  usm_pkg::rgb_t        sharp, res;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      acc[c] = s5_pc_r[c] + s5_pe_r[c] + $signed(PW'(usm_pkg::ROUND_BIAS));
      shv[c] = acc[c] >>> usm_pkg::FRAC_BITS;
      if (shv[c] < $signed(PW'(0))) begin
        sharp[c] = '0;
      end else if (shv[c] > $signed(PW'(usm_pkg::PIX_MAX))) begin
        sharp[c] = usm_pkg::chan_t'(usm_pkg::PIX_MAX);
      end else begin
        sharp[c] = shv[c][usm_pkg::CHAN_W-1:0];
      end
    end
    res = s5_ctl_r.sharpen ? sharp : s5_ctr_r;
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= in_acc;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      out_valid_r <= s5_v_r && s5_ctl_r.emit;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r  <= px_wr;
      s1_col_r <= in_col_r;
      s1_ctl_r <= '{emit: emit, sharpen: interior && sharpen_enable_r, last: emit && last};

      if (s1_v_r) begin
        win_r[0] <= colv;
        for (int j = 1; j < KERNEL_SIZE; j++) begin
          win_r[j] <= win_r[j-1];
        end
      end
      s2_ctl_r <= s1_ctl_r;

      s3_cs_r  <= cs;
      s3_ctr_r <= win_r[HALF][HALF];
      s3_ctl_r <= s2_ctl_r;

      s4_nb_r  <= nb;
      s4_ctr_r <= s3_ctr_r;
      s4_ctl_r <= s3_ctl_r;

      s5_pc_r  <= pc;
      s5_pe_r  <= pe;
      s5_ctr_r <= s4_ctr_r;
      s5_ctl_r <= s4_ctl_r;

      out_rgb_r  <= res;
      out_last_r <= s5_ctl_r.last;
    end
  end

  // Output beat
  assign out_pix.valid   = out_valid_r;
  assign out_pix.payload = {out_rgb_r[0], out_rgb_r[1], out_rgb_r[2], out_last_r};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int KS           = 3;
  localparam int MW           = 4096;
  localparam int HK           = KS / 2;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 16;    // covers the pipeline depth, leave margin
  localparam int IDLE_PCT     = 16;
  localparam int IN_IDLE_PCT  = 8;     // chance of a gap before each beat; about 16% idle
  localparam int MAX_GAP      = 4;
  localparam int RAND_ITEMS   = 600;
  localparam int MAX_REPORTS  = 10;
  localparam int STALL_LIMIT  = 2000;  // cycles without any beat on any channel

  // Index outside the register map, must be ignored
  localparam logic [usm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [usm_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [usm_pkg::CFG_DATA_W-1:0] reg_data;
    usm_pkg::pix_in_t               beat;
    logic                           fixed;
    usm_pkg::pix_out_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  usm_chan_if #(.payload_t(usm_pkg::cfg_wr_t))  cfg_ch ();
  usm_chan_if #(.payload_t(usm_pkg::pix_in_t))  in_ch ();
  usm_chan_if #(.payload_t(usm_pkg::pix_out_t)) out_ch ();

  unsharp_mask_sharpen_core #(
    .KERNEL_SIZE(KS),
    .MAX_WIDTH  (MW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_ch),
    .in_pix (in_ch),
    .out_pix(out_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------
  // Sharpening predictor: own copy of line history, positions, regs
  // ---------------------------------------------------------------
  usm_pkg::rgb_t                        row_history [KS*MW];
  int unsigned                          in_col, in_row, out_col, out_row;
  logic [usm_pkg::WIDTH_REG_W-1:0]      r_width;
  logic [usm_pkg::HEIGHT_W-1:0]         r_height;
  logic signed [usm_pkg::WEIGHT_W-1:0]  r_cw, r_ew;
  logic                                 r_en;

  usm_pkg::pix_out_t pending_pix [$];
  bit                calm = 1'b0;
  int                beats_in, beats_out, frames_done, reg_writes, bad_beats;

  function automatic void reset_model();
    in_col   = 0;
    in_row   = 0;
    out_col  = 0;
    out_row  = 0;
    r_width  = usm_pkg::FRAME_WIDTH_RST;
    r_height = usm_pkg::FRAME_HEIGHT_RST;
    r_cw     = usm_pkg::CENTER_WEIGHT_RST;
    r_ew     = usm_pkg::EDGE_WEIGHT_RST;
    r_en     = usm_pkg::SHARPEN_ENABLE_RST;
  endfunction

  function automatic void apply_reg(logic [usm_pkg::CFG_IDX_W-1:0] idx,
                                    logic [usm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      usm_pkg::CFG_FRAME_WIDTH:    r_width  = data[usm_pkg::WIDTH_REG_W-1:0];
      usm_pkg::CFG_FRAME_HEIGHT:   r_height = data[usm_pkg::HEIGHT_W-1:0];
      usm_pkg::CFG_CENTER_WEIGHT:  r_cw     = data[usm_pkg::WEIGHT_W-1:0];
      usm_pkg::CFG_EDGE_WEIGHT:    r_ew     = data[usm_pkg::WEIGHT_W-1:0];
      usm_pkg::CFG_SHARPEN_ENABLE: r_en     = data[0];
      default: ;
    endcase
  endfunction

  // width saturates to 1..MW, height of zero counts as one row
  function automatic int unsigned eff_w();
    if (r_width == 0) return 1;
    if (r_width > MW) return MW;
    return r_width;
  endfunction

  function automatic int unsigned eff_h();
    return (r_height == 0) ? 1 : r_height;
  endfunction

  function automatic usm_pkg::rgb_t history_at(int unsigned row, int unsigned col);
    return row_history[(row % KS) * MW + (col % MW)];
  endfunction

  // Q10 round half up, floor shift, clamp to a channel
  function automatic usm_pkg::chan_t q10_round(longint acc);
    longint v;
    v = (acc + usm_pkg::ROUND_BIAS) >>> usm_pkg::FRAC_BITS;
    if (v < 0) return '0;
    if (v > usm_pkg::PIX_MAX) return usm_pkg::chan_t'(usm_pkg::PIX_MAX);
    return usm_pkg::chan_t'(v);
  endfunction

  function automatic bit sharpen_pixel(input usm_pkg::pix_in_t beat,
                                       output usm_pkg::pix_out_t res);
    int unsigned     w, h, r, c;
    longint unsigned total, lag, n, m;
    usm_pkg::rgb_t   ctr, tap;
    bit              interior, last;
    longint          acc;
    logic signed [usm_pkg::WEIGHT_W-1:0] wt;
    w     = eff_w();
    h     = eff_h();
    total = longint'(w) * h;
    lag   = longint'(HK) * w + HK;
    n     = longint'(in_row) * w + in_col;
    res   = '0;

    // store the beat; pads inside the frame store black
    if (n < total && in_col < w)
      row_history[(in_row % KS) * MW + in_col] =
        beat.pad ? '0 : {beat.blue_in, beat.green_in, beat.red_in};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (n < lag) return 1'b0;

    r        = out_row;
    c        = out_col;
    ctr      = history_at(r, c);
    interior = r >= HK && r + HK < h && c >= HK && c + HK < w;
    m        = longint'(r) * w + c;
    last     = m + 1 >= total;

    if (interior && r_en) begin
      for (int ch = 0; ch < usm_pkg::NUM_CHAN; ch++) begin
        acc = 0;
        for (int i = 0; i < KS; i++) begin
          for (int j = 0; j < KS; j++) begin
            tap = history_at(r + i - HK, c + j - HK);
            wt  = (i == HK && j == HK) ? r_cw : r_ew;
            acc += longint'(wt) * longint'(tap[ch]);
          end
        end
        ctr[ch] = q10_round(acc);
      end
    end

    res.red_out    = ctr[0];
    res.green_out  = ctr[1];
    res.blue_out   = ctr[2];
    res.frame_last = last;

    // frame end returns every position to zero
    if (last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  function automatic usm_pkg::pix_in_t px(usm_pkg::chan_t r, usm_pkg::chan_t g,
                                          usm_pkg::chan_t b, logic pad);
    usm_pkg::pix_in_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    p.pad      = pad;
    return p;
  endfunction

  function automatic usm_pkg::pix_out_t po(usm_pkg::chan_t r, usm_pkg::chan_t g,
                                           usm_pkg::chan_t b, logic last);
    usm_pkg::pix_out_t p;
    p.red_out    = r;
    p.green_out  = g;
    p.blue_out   = b;
    p.frame_last = last;
    return p;
  endfunction

  function automatic stim_row_t reg_row(logic [usm_pkg::CFG_IDX_W-1:0] idx,
                                        logic [usm_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t beat_row(usm_pkg::pix_in_t beat, logic fixed,
                                         usm_pkg::pix_out_t want);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_PIX;
    row.beat  = beat;
    row.fixed = fixed;
    row.want  = want;
    return row;
  endfunction

  // channel values biased towards the clamp corners
  function automatic usm_pkg::chan_t rand_chan();
    case ($urandom_range(3))
      0:       return '0;
      1:       return usm_pkg::chan_t'(usm_pkg::PIX_MAX);
      default: return usm_pkg::chan_t'($urandom);
    endcase
  endfunction

  function automatic usm_pkg::pix_in_t rand_beat(logic pad);
    return px(rand_chan(), rand_chan(), rand_chan(), pad);
  endfunction

  // lower valid and wait until the block has nothing left in flight
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [usm_pkg::CFG_IDX_W-1:0] idx,
                           logic [usm_pkg::CFG_DATA_W-1:0] data);
    usm_pkg::cfg_wr_t wr;
    settle();
    wr.reg_index = idx;
    wr.wr_data   = data;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= wr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, data);
    reg_writes++;
    @(posedge clk);
  endtask

  // one pixel beat; valid stays up afterwards unless the next call idles
  task automatic push_beat(usm_pkg::pix_in_t beat, logic fixed, usm_pkg::pix_out_t want);
    usm_pkg::pix_out_t res;
    if (!calm && $urandom_range(99) < IN_IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    do @(posedge clk); while (!in_ch.ready);
    beats_in++;
    if (sharpen_pixel(beat, res))
      pending_pix.push_back(fixed ? want : res);
  endtask

  // a whole frame under the current sizes, then exactly the flush beats
  task automatic run_frame();
    longint unsigned pixels, flush;
    pixels = longint'(eff_w()) * eff_h();
    flush  = longint'(HK) * eff_w() + HK;
    for (longint unsigned i = 0; i < pixels; i++)
      push_beat(rand_beat($urandom_range(99) < 4), 1'b0, '0);
    // flush mixes pads with pixel beats whose data is dropped
    for (longint unsigned i = 0; i < flush; i++)
      push_beat(rand_beat($urandom_range(99) < 70), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------
  // Output side: random back-pressure
  // ---------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each output beat with the oldest expected pixel
  always @(posedge clk) begin : check_out
    usm_pkg::pix_out_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      beats_out++;
      if (got.frame_last === 1'b1) frames_done++;
      if (pending_pix.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("%0t: output beat with nothing expected: r%h g%h b%h last%b",
                   $realtime, got.red_out, got.green_out, got.blue_out, got.frame_last);
      end else begin
        want = pending_pix.pop_front();
        if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
            got.blue_out !== want.blue_out || got.frame_last !== want.frame_last) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("%0t: beat %0d want r%h g%h b%h last%b, got r%h g%h b%h last%b",
                     $realtime, beats_out, want.red_out, want.green_out, want.blue_out,
                     want.frame_last, got.red_out, got.green_out, got.blue_out,
                     got.frame_last);
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat for %0d cycles, %0d pixels still expected",
             $realtime, STALL_LIMIT, pending_pix.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin : main_seq
    stim_row_t dir_rows [$];
    int        rand_base, cw_i, ew_i;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    beats_in       = 0;
    beats_out      = 0;
    frames_done    = 0;
    reg_writes     = 0;
    bad_beats      = 0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    // zero sizes: 1x1 frame, two flush beats each
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_WIDTH, 16'h0000));
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_HEIGHT, 16'h0000));
    dir_rows.push_back(beat_row(px(8'hFF, 8'h00, 8'hFF, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'hFF, 8'h00, 1'b1), 1'b0, '0));
    // pixel beat in the flush: its data is dropped, the stored pixel leaves
    dir_rows.push_back(beat_row(px(8'h12, 8'h34, 8'h56, 1'b0), 1'b1,
                                po(8'hFF, 8'h00, 8'hFF, 1'b1)));
    // pad inside the frame stores black
    dir_rows.push_back(beat_row(px(8'hAA, 8'h55, 8'hAA, 1'b1), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'hAA, 8'h55, 8'hAA, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b1,
                                po(8'h00, 8'h00, 8'h00, 1'b1)));
    // 3x3 frame with one interior pixel, extreme weights
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_WIDTH, 16'd3));
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_HEIGHT, 16'd3));
    dir_rows.push_back(reg_row(usm_pkg::CFG_CENTER_WEIGHT, 16'h7FFF));
    dir_rows.push_back(reg_row(usm_pkg::CFG_EDGE_WEIGHT, 16'h8000));
    dir_rows.push_back(reg_row(usm_pkg::CFG_SHARPEN_ENABLE, 16'h0001));
    dir_rows.push_back(beat_row(px(8'h00, 8'hFF, 8'h00, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'hFF, 8'h00, 8'hFF, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h01, 8'h02, 8'h04, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h80, 8'h40, 8'h20, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h10, 8'h08, 8'h7F, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'hFE, 8'hFD, 8'hFB, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h55, 8'hAA, 8'h55, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h12, 8'h34, 8'h56, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0));
    // sharpening off: 2x1 frame passes through
    dir_rows.push_back(reg_row(usm_pkg::CFG_SHARPEN_ENABLE, 16'h0000));
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_WIDTH, 16'd2));
    dir_rows.push_back(reg_row(usm_pkg::CFG_FRAME_HEIGHT, 16'd1));
    dir_rows.push_back(beat_row(px(8'h01, 8'h80, 8'hFE, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h7F, 8'hFE, 8'h01, 1'b0), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b1), 1'b0, '0));
    dir_rows.push_back(beat_row(px(8'h33, 8'h33, 8'h33, 1'b0), 1'b1,
                                po(8'h01, 8'h80, 8'hFE, 1'b0)));
    dir_rows.push_back(beat_row(px(8'h00, 8'h00, 8'h00, 1'b1), 1'b1,
                                po(8'h7F, 8'hFE, 8'h01, 1'b1)));
    dir_rows.push_back(reg_row(CFG_UNMAPPED, 16'hFFFF));
    dir_rows.push_back(reg_row(usm_pkg::CFG_SHARPEN_ENABLE, 16'h0001));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      else
        push_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
    end

    // wider row, three rows for interior taps
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd40);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd3);
    write_reg(usm_pkg::CFG_CENTER_WEIGHT, usm_pkg::CENTER_WEIGHT_RST);
    write_reg(usm_pkg::CFG_EDGE_WEIGHT, usm_pkg::EDGE_WEIGHT_RST);
    run_frame();

    // taller frame, single column
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'd1);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd40);
    run_frame();

    // weight extremes both ways on a small frame; upper width bits are dropped
    write_reg(usm_pkg::CFG_FRAME_WIDTH, 16'hE006);
    write_reg(usm_pkg::CFG_FRAME_HEIGHT, 16'd5);
    write_reg(usm_pkg::CFG_CENTER_WEIGHT, 16'h8000);
    write_reg(usm_pkg::CFG_EDGE_WEIGHT, 16'h7FFF);
    run_frame();
    write_reg(usm_pkg::CFG_CENTER_WEIGHT, 16'h7FFF);
    write_reg(usm_pkg::CFG_EDGE_WEIGHT, 16'h8000);
    run_frame();

    // random phases: small frames, back to back within a setting
    rand_base = beats_in;
    while (beats_in - rand_base < RAND_ITEMS) begin
      write_reg(usm_pkg::CFG_FRAME_WIDTH, ($urandom_range(9) == 0) ? 16'd0 :
                usm_pkg::CFG_DATA_W'($urandom_range(12, 1)));
      write_reg(usm_pkg::CFG_FRAME_HEIGHT, ($urandom_range(9) == 0) ? 16'd0 :
                usm_pkg::CFG_DATA_W'($urandom_range(8, 1)));
      if ($urandom_range(3) == 0) begin
        cw_i = $urandom;
        ew_i = $urandom;
      end else begin
        // unity-gain unsharp mask of random strength
        ew_i = -$urandom_range(400);
        cw_i = 1024 - 8 * ew_i;
      end
      write_reg(usm_pkg::CFG_CENTER_WEIGHT, usm_pkg::CFG_DATA_W'(cw_i));
      write_reg(usm_pkg::CFG_EDGE_WEIGHT, usm_pkg::CFG_DATA_W'(ew_i));
      write_reg(usm_pkg::CFG_SHARPEN_ENABLE,
                ($urandom_range(9) == 0) ? 16'h0000 : 16'h0001);
      if ($urandom_range(7) == 0)
        write_reg(CFG_UNMAPPED, usm_pkg::CFG_DATA_W'($urandom));
      repeat ($urandom_range(3, 1)) begin
        calm = (beats_in - rand_base >= 350) && (beats_in - rand_base < 550);
        run_frame();
      end
    end
    calm = 1'b0;

    settle();
    $display("Covered %0d pixel beats, %0d output beats over %0d frames, %0d register writes",
             beats_in, beats_out, frames_done, reg_writes);
    $display("Sizes from 1x1 up to 40 wide and 40 tall, both weight extremes, on and off");
    if (bad_beats == 0 && pending_pix.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
